@@ hdl/ppp_pkg.sv @@
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared widths, register indexes and item types of the point projection.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int COEF_W    = 32;
  localparam int CFG_W     = 64;
  localparam int SCALE_W   = 14;
  localparam int IDX_W     = 3;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int FLR_W     = PROD_W - FRAC_BITS;
  localparam int DOT_W     = FLR_W + 2;
  localparam int DEN_W     = DOT_W + 1;
  localparam int NUM_W     = DOT_W + SCALE_W + FRAC_BITS;
  localparam int QB        = 41;
  localparam int CMP_W     = DEN_W + QB;
  localparam int RES_W     = QB + SCALE_W + 2;
  localparam int NST       = QB + 3;
  localparam int VIS_MIN   = (2 ** FRAC_BITS + 9) / 10;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  localparam logic [QB-1:0] QUOT_CAP = {1'b1, {(QB - 1){1'b0}}};

  localparam logic [IDX_W-1:0] REG_X_LO = 3'd0;
  localparam logic [IDX_W-1:0] REG_X_HI = 3'd1;
  localparam logic [IDX_W-1:0] REG_Y_LO = 3'd2;
  localparam logic [IDX_W-1:0] REG_Y_HI = 3'd3;
  localparam logic [IDX_W-1:0] REG_D_LO = 3'd4;
  localparam logic [IDX_W-1:0] REG_D_HI = 3'd5;
  localparam logic [IDX_W-1:0] REG_SW   = 3'd6;
  localparam logic [IDX_W-1:0] REG_SH   = 3'd7;

  localparam logic [SCALE_W-1:0] SW_RESET = 14'd640;
  localparam logic [SCALE_W-1:0] SH_RESET = 14'd480;

  typedef struct packed {
    logic [CFG_W-1:0] x_lo;
    logic [CFG_W-1:0] x_hi;
    logic [CFG_W-1:0] y_lo;
    logic [CFG_W-1:0] y_hi;
    logic [CFG_W-1:0] d_lo;
    logic [CFG_W-1:0] d_hi;
  } coef_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] x;
    logic signed [DOT_W-1:0] y;
    logic signed [DOT_W-1:0] w;
    logic                    vis;
  } entry_t;

endpackage

@@ hdl/perspective_point_projection.sv @@
// ----------------------------------------------------------------------------
// perspective_point_projection
// Projects Q16.16 world points to saturated Q16.16 screen coordinates.
// Structure: front register stages, the 4-item queue, then 44 back stages.
// Throughput: one item per unstalled cycle, set by the bit-per-stage divider.
// A 4-item queue lets the front keep accepting while the output is stalled.
// Reset clears pipeline valids, queue pointers and registers (size 640x480).
// ----------------------------------------------------------------------------
module perspective_point_projection (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [ppp_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [ppp_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [ppp_pkg::COORD_W-1:0] point_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               visible_o,
  output logic signed [ppp_pkg::COORD_W-1:0] screen_x_o,
  output logic signed [ppp_pkg::COORD_W-1:0] screen_y_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ppp_pkg::IDX_W-1:0]          cfg_index_i,
  input  logic [ppp_pkg::CFG_W-1:0]          cfg_data_i
);
  import ppp_pkg::*;

  coef_t              coef_q;
  logic [SCALE_W-1:0] sw_q, sh_q;
  logic               push, pop, full, empty;
  entry_t             push_data, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      sw_q   <= SW_RESET;
      sh_q   <= SH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_X_LO: coef_q.x_lo <= cfg_data_i;
        REG_X_HI: coef_q.x_hi <= cfg_data_i;
        REG_Y_LO: coef_q.y_lo <= cfg_data_i;
        REG_Y_HI: coef_q.y_hi <= cfg_data_i;
        REG_D_LO: coef_q.d_lo <= cfg_data_i;
        REG_D_HI: coef_q.d_hi <= cfg_data_i;
        REG_SW:   sw_q        <= cfg_data_i[SCALE_W-1:0];
        REG_SH:   sh_q        <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  ppp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .coef_i     (coef_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_data)
  );

  ppp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head)
  );

  ppp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sw_i        (sw_q),
    .sh_i        (sh_q),
    .empty_i     (empty),
    .data_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .visible_o   (visible_o),
    .screen_x_o  (screen_x_o),
    .screen_y_o  (screen_y_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("queue pop while empty");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !visible_o) |-> (screen_x_o == '0 && screen_y_o == '0))
    else $error("hidden item with nonzero coordinates");

  a_cfg_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_index_i == REG_SW) |=> (sw_q == $past(cfg_data_i[SCALE_W-1:0])))
    else $error("screen width write lost");

endmodule

@@ hdl/ppp_front.sv @@
// ----------------------------------------------------------------------------
// ppp_front
// Accepts points, forms the three dot products and classifies visibility.
// ----------------------------------------------------------------------------
module ppp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ppp_pkg::coef_t                  coef_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [ppp_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [ppp_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [ppp_pkg::COORD_W-1:0] point_z_i,
  input  logic                            full_i,
  output logic                            push_o,
  output ppp_pkg::entry_t                 entry_o
);
  import ppp_pkg::*;

  logic                     en;
  logic                     v1_q, v2_q;
  logic signed [PROD_W-1:0] prod_d [9];
  logic signed [PROD_W-1:0] prod_q [9];
  logic signed [COEF_W-1:0] cf [9];
  logic signed [COORD_W-1:0] pt [9];
  logic signed [DOT_W-1:0]  dot [3];
  entry_t                   entry_q;

  assign cf[0] = coef_i.x_lo[31:0];
  assign cf[1] = coef_i.x_lo[63:32];
  assign cf[2] = coef_i.x_hi[31:0];
  assign cf[3] = coef_i.y_lo[31:0];
  assign cf[4] = coef_i.y_lo[63:32];
  assign cf[5] = coef_i.y_hi[31:0];
  assign cf[6] = coef_i.d_lo[31:0];
  assign cf[7] = coef_i.d_lo[63:32];
  assign cf[8] = coef_i.d_hi[31:0];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      pt[3*r]     = point_x_i;
      pt[3*r + 1] = point_y_i;
      pt[3*r + 2] = point_z_i;
    end
    for (int k = 0; k < 9; k++) begin
      prod_d[k] = cf[k] * pt[k];
    end
  end

  always_comb begin
    logic signed [COEF_W-1:0] off [3];
    off[0] = coef_i.x_hi[63:32];
    off[1] = coef_i.y_hi[63:32];
    off[2] = coef_i.d_hi[63:32];
    for (int r = 0; r < 3; r++) begin
      dot[r] = DOT_W'(prod_q[3*r] >>> FRAC_BITS) + DOT_W'(prod_q[3*r + 1] >>> FRAC_BITS)
             + DOT_W'(prod_q[3*r + 2] >>> FRAC_BITS) + DOT_W'(off[r]);
    end
  end

  assign en         = !(v2_q && full_i);
  assign in_stall_o = !en;
  assign push_o     = v2_q && !full_i;
  assign entry_o    = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        prod_q[k] <= prod_d[k];
      end
      entry_q.x   <= dot[0];
      entry_q.y   <= dot[1];
      entry_q.w   <= dot[2];
      entry_q.vis <= dot[2] >= DOT_W'(VIS_MIN);
    end
  end

endmodule

@@ hdl/ppp_fifo.sv @@
// ----------------------------------------------------------------------------
// ppp_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module ppp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ppp_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output ppp_pkg::entry_t data_o
);
  import ppp_pkg::*;

  entry_t           mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == CNT_W'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PTR_W'(1);
      if (pop_i)  rd_q <= rd_q + PTR_W'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

@@ hdl/ppp_proj.sv @@
// ----------------------------------------------------------------------------
// ppp_proj
// One screen coordinate: scale, pipelined restoring divide, centre, saturate.
// ----------------------------------------------------------------------------
module ppp_proj (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic                               flip_i,
  input  logic signed [ppp_pkg::DOT_W-1:0]   num_i,
  input  logic signed [ppp_pkg::DOT_W-1:0]   w_i,
  input  logic                               vis_i,
  input  logic [ppp_pkg::SCALE_W-1:0]        scale_i,
  output logic                               vis_o,
  output logic signed [ppp_pkg::COORD_W-1:0] res_o
);
  import ppp_pkg::*;

  typedef struct packed {
    logic [DEN_W-1:0]   rem;
    logic [QB-1:0]      low;
    logic [QB-1:0]      q;
    logic [DEN_W-1:0]   den;
    logic               neg;
    logic               vis;
    logic               ovf;
    logic [SCALE_W-1:0] scale;
  } div_stage_t;

  logic [DOT_W-1:0]         mag;
  logic [DOT_W+SCALE_W-1:0] ms;
  logic [NUM_W-1:0]         n_q;
  logic [DEN_W-1:0]         den_q;
  logic                     neg_q, vis_q;
  logic [SCALE_W-1:0]       scale_q;
  div_stage_t               st_q [QB+1];
  div_stage_t               st_d [QB];
  logic                     vis_out_q;
  logic signed [COORD_W-1:0] res_q;
  logic signed [COORD_W-1:0] res_d;

  assign mag = num_i[DOT_W-1] ? DOT_W'(-num_i) : DOT_W'(num_i);
  assign ms  = mag * scale_i;

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      logic [DEN_W:0] trial;
      logic           take;
      trial       = {st_q[k].rem, st_q[k].low[QB-1]};
      take        = trial >= {1'b0, st_q[k].den};
      st_d[k]     = st_q[k];
      st_d[k].rem = take ? DEN_W'(trial - {1'b0, st_q[k].den}) : DEN_W'(trial);
      st_d[k].low = {st_q[k].low[QB-2:0], 1'b0};
      st_d[k].q   = {st_q[k].q[QB-2:0], take};
    end
  end

  always_comb begin
    logic [QB-1:0]           m;
    logic signed [RES_W-1:0] s;
    logic signed [RES_W-1:0] sum;
    m   = (st_q[QB].ovf || st_q[QB].q > QUOT_CAP) ? QUOT_CAP : st_q[QB].q;
    s   = st_q[QB].neg ? -RES_W'(m) : RES_W'(m);
    sum = s + RES_W'({st_q[QB].scale, {FRAC_BITS{1'b0}}} >> 1);
    if (!st_q[QB].vis) begin
      res_d = '0;
    end else if (sum > RES_W'(32'sh7fffffff)) begin
      res_d = 32'sh7fffffff;
    end else if (sum < -RES_W'(33'sh080000000)) begin
      res_d = 32'sh80000000;
    end else begin
      res_d = COORD_W'(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q     <= {ms, {FRAC_BITS{1'b0}}};
      den_q   <= {w_i, 1'b0};
      neg_q   <= num_i[DOT_W-1] ^ flip_i;
      vis_q   <= vis_i;
      scale_q <= scale_i;

      st_q[0].rem   <= DEN_W'(n_q[NUM_W-1:QB]);
      st_q[0].low   <= n_q[QB-1:0];
      st_q[0].q     <= '0;
      st_q[0].den   <= den_q;
      st_q[0].neg   <= neg_q;
      st_q[0].vis   <= vis_q;
      st_q[0].ovf   <= CMP_W'(n_q) >= {den_q, {QB{1'b0}}};
      st_q[0].scale <= scale_q;

      for (int k = 0; k < QB; k++) begin
        st_q[k+1] <= st_d[k];
      end

      vis_out_q <= st_q[QB].vis;
      res_q     <= res_d;
    end
  end

  assign vis_o = vis_out_q;
  assign res_o = res_q;

endmodule

@@ hdl/ppp_back.sv @@
// ----------------------------------------------------------------------------
// ppp_back
// Drains the queue through both coordinate pipelines into the output stage.
// ----------------------------------------------------------------------------
module ppp_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [ppp_pkg::SCALE_W-1:0]        sw_i,
  input  logic [ppp_pkg::SCALE_W-1:0]        sh_i,
  input  logic                               empty_i,
  input  ppp_pkg::entry_t                    data_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               visible_o,
  output logic signed [ppp_pkg::COORD_W-1:0] screen_x_o,
  output logic signed [ppp_pkg::COORD_W-1:0] screen_y_o
);
  import ppp_pkg::*;

  logic           en;
  logic [NST-1:0] vld_q;
  logic           vis_y;

  assign en          = !vld_q[NST-1] || !out_stall_i;
  assign pop_o       = !empty_i && en;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], pop_o};
    end
  end

  ppp_proj u_proj_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .flip_i  (1'b0),
    .num_i   (data_i.x),
    .w_i     (data_i.w),
    .vis_i   (data_i.vis),
    .scale_i (sw_i),
    .vis_o   (visible_o),
    .res_o   (screen_x_o)
  );

  ppp_proj u_proj_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .flip_i  (1'b1),
    .num_i   (data_i.y),
    .w_i     (data_i.w),
    .vis_i   (data_i.vis),
    .scale_i (sh_i),
    .vis_o   (vis_y),
    .res_o   (screen_y_o)
  );

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for perspective_point_projection: points go in under
// random input gaps and output stalls, each result is compared with a
// fixed-point projection predicted here, across several coefficient and
// viewport settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import ppp_pkg::*;

  typedef struct {
    logic                      vis;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
  } screen_pt_t;

  localparam int HOLD_LEN = 300;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [COORD_W-1:0] point_x_i = '0;
  logic signed [COORD_W-1:0] point_y_i = '0;
  logic signed [COORD_W-1:0] point_z_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      visible_o;
  logic signed [COORD_W-1:0] screen_x_o;
  logic signed [COORD_W-1:0] screen_y_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [IDX_W-1:0]          cfg_index_i = '0;
  logic [CFG_W-1:0]          cfg_data_i = '0;

  logic [CFG_W-1:0]   row_x_lo, row_x_hi, row_y_lo, row_y_hi, row_d_lo, row_d_hi;
  logic [SCALE_W-1:0] view_w, view_h;

  screen_pt_t pending_pts[$];
  int         n_errors = 0;
  int         cycles = 0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_cycles = 0;
  bit         quiet = 1'b0;
  int         gap_pct = 30;

  perspective_point_projection DUT (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic longint row_dot(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi,
                                     longint px, longint py, longint pz);
    longint a, b, c, o;
    a = longint'($signed(lo[31:0]));
    b = longint'($signed(lo[63:32]));
    c = longint'($signed(hi[31:0]));
    o = longint'($signed(hi[63:32]));
    return ((a * px) >>> FRAC_BITS) + ((b * py) >>> FRAC_BITS) +
           ((c * pz) >>> FRAC_BITS) + o;
  endfunction

  function automatic logic signed [COORD_W-1:0] to_screen(longint num,
      logic [SCALE_W-1:0] scale, longint w, bit flip);
    logic [127:0] n, q;
    longint s, ctr, r;
    bit neg;
    neg = num < 0;
    n = 128'(neg ? -num : num);
    n = (n * scale) << FRAC_BITS;
    q = n / (128'(w) * 2);
    if (q > (128'(1) << 40)) q = 128'(1) << 40;
    s = longint'(q[63:0]);
    if (neg != flip) s = -s;
    ctr = (longint'(scale) << FRAC_BITS) >>> 1;
    r = s + ctr;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic screen_pt_t project_point(logic signed [COORD_W-1:0] x,
      logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
    screen_pt_t p;
    longint w, cx, cy;
    w = row_dot(row_d_lo, row_d_hi, x, y, z);
    p = '{1'b0, '0, '0};
    if (w * 10 >= (longint'(1) << FRAC_BITS)) begin
      cx = row_dot(row_x_lo, row_x_hi, x, y, z);
      cy = row_dot(row_y_lo, row_y_hi, x, y, z);
      p.vis = 1'b1;
      p.sx = to_screen(cx, view_w, w, 1'b0);
      p.sy = to_screen(cy, view_h, w, 1'b1);
    end
    return p;
  endfunction

  task automatic report(string what, logic signed [COORD_W-1:0] got,
                        logic signed [COORD_W-1:0] want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    n_errors++;
  endtask

  // accepted items
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      pending_pts.push_back(project_point(point_x_i, point_y_i, point_z_i));
  end

  // results
  always @(posedge clk_i) begin
    screen_pt_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pts.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        e = pending_pts.pop_front();
        if (visible_o !== e.vis) report("visible", visible_o, e.vis);
        if (screen_x_o !== e.sx) report("screen_x", screen_x_o, e.sx);
        if (screen_y_o !== e.sy) report("screen_y", screen_y_o, e.sy);
      end
    end
  end

  // output stalls
  always @(negedge clk_i) begin
    int burst;
    if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_cycles <= HOLD_LEN - 1;
      out_stall_i <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (burst > 0) begin
      burst--;
    end else if ($urandom_range(0, 99) < 25) begin
      out_stall_i <= 1'b1;
      burst = $urandom_range(1, 16) - 1;
    end else begin
      out_stall_i <= 1'b0;
      burst = $urandom_range(0, 20);
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    point_x_i  <= x;
    point_y_i  <= y;
    point_z_i  <= z;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_pts.size() == 0);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_X_LO: row_x_lo = data;
      REG_X_HI: row_x_hi = data;
      REG_Y_LO: row_y_lo = data;
      REG_Y_HI: row_y_hi = data;
      REG_D_LO: row_d_lo = data;
      REG_D_HI: row_d_hi = data;
      REG_SW:   view_w = data[SCALE_W-1:0];
      default:  view_h = data[SCALE_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [13:0] pick_size();
    case ($urandom_range(0, 6))
      0: return 14'd0;
      1: return 14'd1;
      2: return 14'd8192;
      3: return 14'd16383;
      4: return 14'd640;
      default: return 14'($urandom_range(1, 8192));
    endcase
  endfunction

  function automatic logic [31:0] near(int units);
    return 32'($urandom_range(0, 2 * units * 65536)) - 32'(units * 65536);
  endfunction

  // style 0: camera-like, 1: random, 2: extreme coefficients
  task automatic load_setting(int style);
    logic [31:0] one, big;
    drain();
    one = 32'h0001_0000;
    case (style)
      0: begin
        write_reg(REG_X_LO, {32'h0, one});
        write_reg(REG_X_HI, {near(20), 32'h0});
        write_reg(REG_Y_LO, {one, 32'h0});
        write_reg(REG_Y_HI, {near(20), 32'h0});
        write_reg(REG_D_LO, {near(1) >>> 3, near(1) >>> 3});
        write_reg(REG_D_HI, {near(4), one});
      end
      1: begin
        write_reg(REG_X_LO, {$urandom, $urandom});
        write_reg(REG_X_HI, {$urandom, $urandom});
        write_reg(REG_Y_LO, {$urandom, $urandom});
        write_reg(REG_Y_HI, {$urandom, $urandom});
        write_reg(REG_D_LO, {$urandom, $urandom});
        write_reg(REG_D_HI, {$urandom, $urandom});
      end
      default: begin
        big = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        write_reg(REG_X_LO, {big, ~big});
        write_reg(REG_X_HI, {big, big});
        write_reg(REG_Y_LO, {~big, big});
        write_reg(REG_Y_HI, {~big, ~big});
        write_reg(REG_D_LO, {big, big});
        write_reg(REG_D_HI, {32'h7fff_ffff, big});
      end
    endcase
    write_reg(REG_SW, 64'(pick_size()));
    write_reg(REG_SH, 64'(pick_size()));
  endtask

  task automatic send_random(int style);
    if (style == 0 && $urandom_range(0, 9) < 8)
      send_point(near(100), near(100), near(30));
    else
      send_point($urandom, $urandom, $urandom);
  endtask

  // reset values, then depth right at the visibility threshold, then extreme points and sizes
  task automatic test_directed();
    send_point(32'h0, 32'h0, 32'h0);
    drain();
    write_reg(REG_X_LO, {32'h0, 32'h0001_0000});
    write_reg(REG_Y_LO, {32'h0001_0000, 32'h0});
    write_reg(REG_D_LO, 64'h0);
    write_reg(REG_D_HI, {32'd6553, 32'h0});
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0);
    drain();
    write_reg(REG_D_HI, {32'd6554, 32'h0});
    send_point(32'h0001_0000, 32'hffff_0000, 32'h0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_point(32'h0, 32'h0, 32'h0);
    drain();
    write_reg(REG_SW, 64'd0);
    write_reg(REG_SH, 64'd16383);
    send_point(32'h0003_0000, 32'h7fff_ffff, 32'h0);
    send_point(32'hffff_ffff, 32'h0000_0001, 32'h0);
    drain();
    write_reg(REG_SW, 64'd8192);
    write_reg(REG_SH, 64'd1);
    write_reg(REG_D_HI, {32'h0001_0000, 32'h0001_0000});
    send_point(32'h0, 32'h0, 32'hffff_0000);
    send_point(32'h0, 32'h0, 32'hffff_e000);
    send_point(32'h0005_0000, 32'hfffb_0000, 32'h0002_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
  endtask

  task automatic test_random();
    int style;
    for (int k = 0; k < 10; k++) begin
      style = k % 3;
      load_setting(style);
      repeat (50) send_random(style);
    end
  endtask

  // long output hold fills the pipeline, then a pause until empty and more points
  task automatic test_backpressure();
    load_setting(0);
    hold_req++;
    gap_pct = 0;
    repeat (60) send_random(0);
    gap_pct = 30;
    drain();
    repeat (30) send_random(0);
  endtask

  task automatic test_no_idle();
    load_setting(1);
    quiet = 1'b1;
    repeat (40) send_random(1);
  endtask

  initial begin
    row_x_lo = '0; row_x_hi = '0; row_y_lo = '0; row_y_hi = '0;
    row_d_lo = '0; row_d_hi = '0;
    view_w = SW_RESET;
    view_h = SH_RESET;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    test_no_idle();
    drain();
    if (n_errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ppp_pkg.sv
hdl/ppp_front.sv
hdl/ppp_fifo.sv
hdl/ppp_proj.sv
hdl/ppp_back.sv
hdl/perspective_point_projection.sv
test/tb.sv
